[hdl/ffsa_pkg.sv]
// Shared types and constants of the first-fit slot allocator.
// No dependencies; used by ffsa_ctrl, ffsa_dpath and the top level.
`default_nettype none

package ffsa_pkg;

    // default geometry of the heap
    localparam int SLOT_COUNT_DEF = 512;
    localparam int SLOT_BYTES_DEF = 8;

    // request and result field widths
    localparam int CMD_W    = 2;
    localparam int SIZE_W   = 16;
    localparam int PTR_W    = 12;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 12;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_BAD   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_NOMEM  = 2'd1,
        STAT_BADPTR = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SLOT_FREE = 2'd0,
        SLOT_USED = 2'd1,
        SLOT_BASE = 2'd2
    } t_slot;

    // result to latch into the pending result register
    typedef enum logic [2:0] {
        RES_NONE   = 3'd0,
        RES_NOMEM  = 3'd1,
        RES_BADPTR = 3'd2,
        RES_ALLOC  = 3'd3,
        RES_SIZE   = 3'd4,
        RES_OK0    = 3'd5
    } t_res;

    typedef enum logic [3:0] {
        S_CLEAR   = 4'd0,
        S_IDLE    = 4'd1,
        S_PRE     = 4'd2,
        S_DIV     = 4'd3,
        S_SCAN    = 4'd4,
        S_MARK    = 4'd5,
        S_CHECK   = 4'd6,
        S_RELEASE = 4'd7,
        S_DONE    = 4'd8
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic clr_step;
        logic load;
        logic div_step;
        logic scan_start;
        logic scan_step;
        logic look;
        logic check;
        logic mark_step;
        logic rel_step;
        logic emit;
        t_res res;
    } t_dp_ctl;

    // datapath -> controller status
    typedef struct packed {
        t_cmd cmd;
        logic clr_last;
        logic bad_size;
        logic bad_ptr;
        logic div_done;
        logic rem_nz;
        logic is_base;
        logic len_zero;
        logic scan_found;
        logic scan_fail;
        logic mark_last;
        logic rel_last;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

[hdl/ffsa_ctrl.sv]
// Sequencer of the first-fit slot allocator.
// Depends on ffsa_pkg; drives ffsa_dpath through t_dp_ctl.
`default_nettype none

module ffsa_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_valid,
    output logic             o_s_ready,
    input  ffsa_pkg::t_dp_sts i_sts,
    output ffsa_pkg::t_dp_ctl o_ctl
);
    import ffsa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_valid) n_state = S_PRE;
            end
            S_PRE: begin
                case (i_sts.cmd)
                    CMD_ALLOC: n_state = i_sts.bad_size ? S_DONE : S_DIV;
                    CMD_FREE, CMD_QUERY: n_state = i_sts.bad_ptr ? S_DONE : S_DIV;
                    default: n_state = S_DONE;
                endcase
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.cmd == CMD_ALLOC) n_state = S_SCAN;
                    else if (i_sts.rem_nz)      n_state = S_DONE;
                    else                        n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.is_base || i_sts.cmd == CMD_QUERY || i_sts.len_zero)
                    n_state = S_DONE;
                else
                    n_state = S_RELEASE;
            end
            S_SCAN: begin
                if (i_sts.scan_found)     n_state = S_MARK;
                else if (i_sts.scan_fail) n_state = S_DONE;
            end
            S_MARK: begin
                if (i_sts.mark_last) n_state = S_DONE;
            end
            S_RELEASE: begin
                if (i_sts.rel_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_ctl     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_ctl.load = i_s_valid;
            end
            S_PRE: begin
                case (i_sts.cmd)
                    CMD_ALLOC: begin
                        if (i_sts.bad_size) o_ctl.res = RES_NOMEM;
                    end
                    CMD_FREE, CMD_QUERY: begin
                        if (i_sts.bad_ptr) o_ctl.res = RES_BADPTR;
                    end
                    default: o_ctl.res = RES_NOMEM;
                endcase
            end
            S_DIV: begin
                if (!i_sts.div_done)             o_ctl.div_step   = 1'b1;
                else if (i_sts.cmd == CMD_ALLOC) o_ctl.scan_start = 1'b1;
                else if (i_sts.rem_nz)           o_ctl.res        = RES_BADPTR;
                else                             o_ctl.look       = 1'b1;
            end
            S_CHECK: begin
                o_ctl.check = 1'b1;
                if (!i_sts.is_base)              o_ctl.res = RES_BADPTR;
                else if (i_sts.cmd == CMD_QUERY) o_ctl.res = RES_SIZE;
                else if (i_sts.len_zero)         o_ctl.res = RES_OK0;
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.scan_fail) o_ctl.res = RES_NOMEM;
            end
            S_MARK: begin
                o_ctl.mark_step = 1'b1;
                if (i_sts.mark_last) o_ctl.res = RES_ALLOC;
            end
            S_RELEASE: begin
                o_ctl.rel_step = 1'b1;
                if (i_sts.rel_last) o_ctl.res = RES_OK0;
            end
            S_DONE: begin
                o_ctl.emit = !i_sts.out_busy;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/ffsa_dpath.sv]
// Datapath of the first-fit slot allocator: slot state and length memories,
// reciprocal divider, scan cursor, pending result and output register.
// Depends on ffsa_pkg; sequenced by ffsa_ctrl.
`default_nettype none

module ffsa_dpath #(
    parameter int SLOT_COUNT = ffsa_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = ffsa_pkg::SLOT_BYTES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  ffsa_pkg::t_dp_ctl                 i_ctl,
    output ffsa_pkg::t_dp_sts                 o_sts,
    input  wire [ffsa_pkg::CMD_W-1:0]         i_cmd,
    input  wire [ffsa_pkg::SIZE_W-1:0]        i_size_bytes,
    input  wire [ffsa_pkg::PTR_W-1:0]         i_pointer,
    input  wire                              i_out_ready,
    output logic                             o_out_valid,
    output logic [ffsa_pkg::STATUS_W-1:0]     o_status,
    output logic [ffsa_pkg::VALUE_W-1:0]      o_value
);
    import ffsa_pkg::*;

    localparam int SW  = $clog2(SLOT_COUNT);
    localparam int CW  = SW + 1;
    localparam int DW  = (SW + 7 > 17) ? SW + 7 : 17;
    localparam int DCW = 2;
    localparam int PW  = SW + 7;
    localparam int MAX_BYTES  = (SLOT_COUNT - 1) * SLOT_BYTES;
    localparam int HEAP_BYTES = SLOT_COUNT * SLOT_BYTES;
    localparam logic [CW-1:0] LAST_IDX = CW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] END_IDX  = CW'(SLOT_COUNT);
    // floor(x / SLOT_BYTES) = (x * RECIP) >> RSH, exact for any DW-bit x
    localparam int RSH = DW + $clog2(SLOT_BYTES);
    localparam int RW  = DW + 1;
    localparam int QW  = DW + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'(1) << RSH) + 64'(SLOT_BYTES - 1)) / 64'(SLOT_BYTES));
    localparam logic [DCW-1:0] DIV_STEPS = DCW'(2);

    // memories
    t_slot           r_slot_mem [SLOT_COUNT];
    logic [SW-1:0]   r_len_mem  [SLOT_COUNT];
    t_slot           r_rd_state;
    logic [SW-1:0]   r_rd_len;

    // captured request
    t_cmd                r_cmd;
    logic [SIZE_W-1:0]   r_size;
    logic [PTR_W-1:0]    r_ptr;

    // divider
    logic [DW-1:0]  r_rem;
    logic [SW-1:0]  r_quo;
    logic [DCW-1:0] r_dcnt;

    // cursor
    logic [CW-1:0]  r_cur;
    logic [SW-1:0]  r_cnt;
    logic [SW-1:0]  r_start;
    logic           r_run;

    // results
    t_status             r_res_status;
    logic [VALUE_W-1:0]  r_res_value;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [VALUE_W-1:0]  r_out_value;

    logic [SW-1:0]  rd_addr;
    logic [SW-1:0]  step_len;
    logic [CW-1:0]  cur_inc;
    logic [SW-1:0]  cnt_inc;
    logic [CW-1:0]  scan_nxt;
    logic           scan_run_n;
    logic           scan_found;
    logic           scan_fail;
    logic [SW-1:0]  found_start;
    logic [DW-1:0]  dividend;
    logic [QW-1:0]  quo_prod;
    logic [DW-1:0]  quo_bytes;
    logic [PW-1:0]  prod_start;
    logic [PW-1:0]  prod_len;
    logic           wr_state_en;
    t_slot          wr_state;
    logic           wr_len_en;
    logic           at_start;

    // scan step: r_rd_state / r_rd_len belong to slot r_cur
    always_comb begin
        step_len   = (r_rd_len == '0) ? SW'(1) : r_rd_len;
        cur_inc    = r_cur + CW'(1);
        cnt_inc    = r_cnt + SW'(1);
        scan_nxt   = cur_inc;
        scan_run_n = r_run;
        scan_found = 1'b0;
        scan_fail  = 1'b0;
        if (!r_run) begin
            case (r_rd_state)
                SLOT_BASE: begin
                    scan_nxt  = r_cur + CW'(step_len);
                    scan_fail = (scan_nxt >= LAST_IDX);
                end
                SLOT_FREE: begin
                    if (r_quo == SW'(1)) scan_found = 1'b1;
                    else                 scan_run_n = 1'b1;
                end
                default: begin
                    scan_fail = (cur_inc >= LAST_IDX);
                end
            endcase
        end else begin
            if (r_rd_state == SLOT_FREE) begin
                if (cnt_inc == r_quo) scan_found = 1'b1;
                else                  scan_fail  = (cur_inc >= END_IDX);
            end else begin
                scan_run_n = 1'b0;
                scan_fail  = (cur_inc >= LAST_IDX);
            end
        end
        found_start = r_run ? r_start : r_cur[SW-1:0];
    end

    // read address
    always_comb begin
        rd_addr = r_cur[SW-1:0];
        if (i_ctl.scan_start)
            rd_addr = '0;
        else if (i_ctl.look)
            rd_addr = r_quo;
        else if (i_ctl.scan_step && !scan_found && !scan_fail)
            rd_addr = scan_nxt[SW-1:0];
    end

    // write port
    always_comb begin
        at_start    = (r_cur[SW-1:0] == r_start);
        wr_state_en = i_ctl.clr_step | i_ctl.mark_step | i_ctl.rel_step;
        wr_state    = SLOT_FREE;
        if (i_ctl.mark_step) wr_state = at_start ? SLOT_BASE : SLOT_USED;
        wr_len_en   = i_ctl.mark_step & at_start;
    end

    always_ff @(posedge i_clk) begin
        if (wr_state_en) r_slot_mem[r_cur[SW-1:0]] <= wr_state;
        if (wr_len_en)   r_len_mem[r_cur[SW-1:0]]  <= r_quo;
        r_rd_state <= r_slot_mem[rd_addr];
        r_rd_len   <= r_len_mem[rd_addr];
    end

    // request capture and divider
    assign dividend = (t_cmd'(i_cmd) == CMD_ALLOC)
                    ? DW'(i_size_bytes) + DW'(SLOT_BYTES - 1)
                    : DW'(i_pointer);

    // first step: quotient by reciprocal; second step: remainder
    assign quo_prod  = QW'(r_rem) * QW'(RECIP);
    assign quo_bytes = DW'(r_quo) * DW'(SLOT_BYTES);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_size <= i_size_bytes;
            r_ptr  <= i_pointer;
            r_rem  <= dividend;
            r_quo  <= '0;
        end else if (i_ctl.div_step) begin
            if (r_dcnt == DIV_STEPS) begin
                r_quo <= quo_prod[RSH +: SW];
            end else begin
                r_rem <= r_rem - quo_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_ctl.load) begin
            r_dcnt <= DIV_STEPS;
        end else if (i_ctl.div_step) begin
            r_dcnt <= r_dcnt - DCW'(1);
        end
    end

    // cursor: clear pass, scan, mark and release walks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_cnt   <= '0;
            r_start <= '0;
            r_run   <= 1'b0;
        end else if (i_ctl.clr_step || i_ctl.mark_step || i_ctl.rel_step) begin
            r_cur <= cur_inc;
            r_cnt <= r_cnt - SW'(1);
        end else if (i_ctl.scan_start) begin
            r_cur <= '0;
            r_run <= 1'b0;
        end else if (i_ctl.check) begin
            r_cur <= CW'(r_quo);
            r_cnt <= r_rd_len;
        end else if (i_ctl.scan_step) begin
            if (scan_found) begin
                r_start <= found_start;
                r_cur   <= CW'(found_start);
                r_cnt   <= r_quo;
            end else if (!scan_fail) begin
                r_cur <= scan_nxt;
                r_run <= scan_run_n;
                if (!r_run && r_rd_state == SLOT_FREE) begin
                    r_start <= r_cur[SW-1:0];
                    r_cnt   <= SW'(1);
                end else if (r_run && r_rd_state == SLOT_FREE) begin
                    r_cnt <= cnt_inc;
                end
            end
        end
    end

    // pending result
    assign prod_start = PW'(r_start) * PW'(SLOT_BYTES);
    assign prod_len   = PW'(r_rd_len) * PW'(SLOT_BYTES);

    always_ff @(posedge i_clk) begin
        case (i_ctl.res)
            RES_NOMEM: begin
                r_res_status <= STAT_NOMEM;
                r_res_value  <= '0;
            end
            RES_BADPTR: begin
                r_res_status <= STAT_BADPTR;
                r_res_value  <= '0;
            end
            RES_ALLOC: begin
                r_res_status <= STAT_OK;
                r_res_value  <= VALUE_W'(prod_start);
            end
            RES_SIZE: begin
                r_res_status <= STAT_OK;
                r_res_value  <= VALUE_W'(prod_len);
            end
            RES_OK0: begin
                r_res_status <= STAT_OK;
                r_res_value  <= '0;
            end
            default: begin
                r_res_status <= r_res_status;
                r_res_value  <= r_res_value;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value     = r_out_value;

    // status to the controller
    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.clr_last   = (r_cur[SW-1:0] == LAST_IDX[SW-1:0]);
        o_sts.bad_size   = (r_size == '0) || (32'(r_size) > 32'(MAX_BYTES));
        o_sts.bad_ptr    = (32'(r_ptr) >= 32'(HEAP_BYTES));
        o_sts.div_done   = (r_dcnt == '0);
        o_sts.rem_nz     = (r_rem != '0);
        o_sts.is_base    = (r_rd_state == SLOT_BASE);
        o_sts.len_zero   = (r_rd_len == '0);
        o_sts.scan_found = scan_found;
        o_sts.scan_fail  = scan_fail;
        o_sts.mark_last  = (r_cnt == SW'(1));
        o_sts.rel_last   = (r_cnt == SW'(1)) || (r_cur == LAST_IDX);
        o_sts.out_busy   = r_out_valid & ~i_out_ready;
    end

endmodule

`default_nettype wire

[hdl/first_fit_slot_allocator_top.sv]
// First-fit slot allocator over a heap of SLOT_COUNT slots of SLOT_BYTES bytes.
// Reset: synchronous, active low; then a clearing pass frees every slot while
// s_axis_tready stays low. The allocation scan visits one slot or skipped block per
// cycle. One request at a time; the next is taken the cycle after the result loads.
`default_nettype none

module first_fit_slot_allocator_top #(
    parameter int SLOT_COUNT = ffsa_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = ffsa_pkg::SLOT_BYTES_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // request stream
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] cmd, [17:2] size_bytes, [29:18] pointer, [31:30] zero
    input  wire [ffsa_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [1:0] status, [13:2] value, [15:14] zero
    output logic [ffsa_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import ffsa_pkg::*;

    t_dp_ctl               ctl;
    t_dp_sts               sts;
    logic [CMD_W-1:0]      req_cmd;
    logic [SIZE_W-1:0]     req_size;
    logic [PTR_W-1:0]      req_ptr;
    logic [STATUS_W-1:0]   res_status;
    logic [VALUE_W-1:0]    res_value;

    // request unpacking
    assign req_cmd  = s_axis_tdata[CMD_W-1:0];
    assign req_size = s_axis_tdata[CMD_W+SIZE_W-1:CMD_W];
    assign req_ptr  = s_axis_tdata[CMD_W+SIZE_W+PTR_W-1:CMD_W+SIZE_W];

    // sequencer: clear pass, divide, scan/mark or check/release, then hand off
    ffsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_ctl     (ctl)
    );

    // memories, divider, cursor and output register; the output register lets
    // a new request be taken while the previous result waits downstream
    ffsa_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_cmd        (req_cmd),
        .i_size_bytes (req_size),
        .i_pointer    (req_ptr),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_status     (res_status),
        .o_value      (res_value)
    );

    // result packing
    assign m_axis_tdata = {{(M_TDATA_W - STATUS_W - VALUE_W){1'b0}}, res_value, res_status};

endmodule

`default_nettype wire

[sim/first_fit_slot_allocator_top_tb.sv]
// Self-checking bench for first_fit_slot_allocator_top: heap requests go in on the
// request stream, a slot-level heap predictor forecasts each status/value result.
// Depends on ffsa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module first_fit_slot_allocator_top_tb;
    import ffsa_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int SLOT_B       = SLOT_BYTES_DEF;
    localparam int RAND_PER_PHASE = 340;
    localparam int STALL_LIMIT  = 20000;   // clear pass plus worst scan, many times over
    localparam int TAIL_CYCLES  = 200;
    localparam int MAX_PRINTS   = 30;

    // one queued request, or a phase marker that drains the block first
    typedef struct {
        bit                 phase_mark;
        int                 send_idle;
        int                 recv_idle;
        t_cmd               cmd;
        logic [SIZE_W-1:0]  size;
        logic [PTR_W-1:0]   ptr;
    } heap_req_t;

    typedef struct {
        t_status            status;
        logic [VALUE_W-1:0] value;
    } heap_res_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;   // [1:0] cmd, [17:2] size, [29:18] ptr
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;        // [1:0] status, [13:2] value

    first_fit_slot_allocator_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted heap image
    t_slot          heap_slot [SLOTS];
    logic [9:0]     heap_len  [SLOTS];
    int unsigned    live_blocks [$];     // byte offsets of blocks believed allocated

    heap_req_t      pending_reqs [$];
    heap_res_t      expected_results [$];
    heap_req_t      in_flight;
    heap_res_t      want;
    bit             launch_now;

    int send_idle_pct = 18;
    int recv_idle_pct = 73;
    int mismatches = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int allocs_granted = 0;
    int frees_done = 0;
    int queries_done = 0;
    int nomem_answers = 0;
    int badptr_answers = 0;
    int drains = 0;
    int idle_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int exp);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, exp);
        mismatches++;
    endtask

    // first-fit walk from slot 0; steps over whole blocks, -1 when nothing fits
    function automatic int find_first_fit(input int need);
        int  i;
        int  j;
        bit  fits;
        i = 0;
        while (i < SLOTS - 1) begin
            if (heap_slot[i] == SLOT_BASE) begin
                i += (heap_len[i] == 0) ? 1 : int'(heap_len[i]);
            end else if (heap_slot[i] == SLOT_FREE) begin
                fits = 1'b1;
                j = 0;
                while (fits && j < need) begin
                    if (i + j >= SLOTS)
                        return -1;          // run would pass the last slot
                    if (heap_slot[i + j] != SLOT_FREE)
                        fits = 1'b0;
                    else
                        j++;
                end
                if (fits)
                    return i;
                i += j + 1;                 // resume past the blocking slot
            end else begin
                i++;
            end
        end
        return -1;
    endfunction

    task automatic predict_heap_result(input heap_req_t r);
        int        need;
        int        start;
        int        idx;
        int        k;
        heap_res_t res;
        res.status = STAT_NOMEM;
        res.value  = '0;
        case (r.cmd)
            CMD_ALLOC: begin
                need = (int'(r.size) + SLOT_B - 1) / SLOT_B;
                if (need != 0 && need <= SLOTS - 1) begin
                    start = find_first_fit(need);
                    if (start >= 0) begin
                        heap_slot[start] = SLOT_BASE;
                        heap_len[start]  = 10'(need);
                        for (k = 1; k < need; k++)
                            heap_slot[start + k] = SLOT_USED;
                        res.status = STAT_OK;
                        res.value  = VALUE_W'(start * SLOT_B);
                        live_blocks.push_back(start * SLOT_B);
                        allocs_granted++;
                    end
                end
            end
            CMD_FREE, CMD_QUERY: begin
                idx = int'(r.ptr) / SLOT_B;
                if ((int'(r.ptr) % SLOT_B) != 0 || idx >= SLOTS || heap_slot[idx] != SLOT_BASE) begin
                    res.status = STAT_BADPTR;
                end else begin
                    res.status = STAT_OK;
                    if (r.cmd == CMD_FREE) begin
                        for (k = 0; k < int'(heap_len[idx]) && idx + k < SLOTS; k++)
                            heap_slot[idx + k] = SLOT_FREE;
                        for (k = 0; k < live_blocks.size(); k++)
                            if (live_blocks[k] == idx * SLOT_B) begin
                                live_blocks.delete(k);
                                break;
                            end
                        frees_done++;
                    end else begin
                        res.value = VALUE_W'(int'(heap_len[idx]) * SLOT_B);
                        queries_done++;
                    end
                end
            end
            default: ;                      // unknown command: no state change
        endcase
        if (res.status == STAT_NOMEM)
            nomem_answers++;
        if (res.status == STAT_BADPTR)
            badptr_answers++;
        expected_results.push_back(res);
    endtask

    task automatic queue_request(input t_cmd c, input logic [SIZE_W-1:0] sz,
                                 input logic [PTR_W-1:0] p);
        heap_req_t r;
        r.phase_mark = 1'b0;
        r.send_idle  = 0;
        r.recv_idle  = 0;
        r.cmd        = c;
        r.size       = sz;
        r.ptr        = p;
        pending_reqs.push_back(r);
    endtask

    // wait for the block to drain, then switch idle rates
    task automatic queue_phase(input int send_pct, input int recv_pct);
        heap_req_t r;
        r.phase_mark = 1'b1;
        r.send_idle  = send_pct;
        r.recv_idle  = recv_pct;
        r.cmd        = CMD_ALLOC;
        r.size       = '0;
        r.ptr        = '0;
        pending_reqs.push_back(r);
    endtask

    // mostly well-formed traffic on live blocks, some noise and stale pointers
    task automatic queue_random_request();
        int                pick;
        int unsigned       base;
        int                alloc_pct;
        logic [SIZE_W-1:0] sz;
        pick = $urandom_range(0, 99);
        alloc_pct = (live_blocks.size() > 24) ? 25 : 50;
        if (live_blocks.size() > 0)
            base = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        else
            base = $urandom_range(0, SLOTS - 1) * SLOT_B;
        if (pick < alloc_pct) begin
            case ($urandom_range(0, 19))
                0:          sz = '0;
                1:          sz = SIZE_W'($urandom);
                2, 3:       sz = SIZE_W'($urandom_range(1025, 4096));
                4, 5, 6, 7: sz = SIZE_W'($urandom_range(129, 1024));
                default:    sz = SIZE_W'($urandom_range(1, 128));
            endcase
            queue_request(CMD_ALLOC, sz, PTR_W'($urandom));
        end else if (pick < 75) begin
            queue_request(CMD_FREE, SIZE_W'($urandom), PTR_W'(base));
        end else if (pick < 90) begin
            queue_request(CMD_QUERY, SIZE_W'($urandom), PTR_W'(base));
        end else begin
            case ($urandom_range(0, 3))
                0: queue_request(t_cmd'($urandom_range(0, 3)), SIZE_W'($urandom),
                                 PTR_W'($urandom));
                1: queue_request($urandom_range(0, 1) ? CMD_FREE : CMD_QUERY,
                                 SIZE_W'($urandom), PTR_W'(base + $urandom_range(1, 7)));
                2: queue_request($urandom_range(0, 1) ? CMD_FREE : CMD_QUERY,
                                 SIZE_W'($urandom),
                                 PTR_W'(base + SLOT_B * $urandom_range(1, 4)));
                default: queue_request(CMD_BAD, SIZE_W'($urandom), PTR_W'($urandom));
            endcase
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_heap_result(in_flight);
                requests_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                launch_now = 1'b0;
                if (pending_reqs.size() > 0 && pending_reqs[0].phase_mark) begin
                    if (!s_axis_tvalid && expected_results.size() == 0) begin
                        send_idle_pct = pending_reqs[0].send_idle;
                        recv_idle_pct = pending_reqs[0].recv_idle;
                        void'(pending_reqs.pop_front());
                        drains++;
                    end
                end else if (pending_reqs.size() > 0 &&
                             $urandom_range(0, 99) >= send_idle_pct) begin
                    in_flight  = pending_reqs.pop_front();
                    launch_now = 1'b1;
                end
                s_axis_tvalid <= launch_now;
                if (launch_now)
                    s_axis_tdata <= {2'b00, in_flight.ptr, in_flight.size, in_flight.cmd};
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", int'(m_axis_tdata[1:0]), -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[1:0] !== want.status)
                        report_mismatch("status", int'(m_axis_tdata[1:0]), int'(want.status));
                    if (m_axis_tdata[13:2] !== want.value)
                        report_mismatch("value", int'(m_axis_tdata[13:2]), int'(want.value));
                end
                results_seen++;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int i;
        int n;
        for (i = 0; i < SLOTS; i++) begin
            heap_slot[i] = SLOT_FREE;
            heap_len[i]  = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: size limits, pointer checks, end-of-heap behavior
        queue_request(CMD_ALLOC, 16'd0, 12'd0);          // zero size
        queue_request(CMD_QUERY, 16'hFFFF, 12'd0);       // nothing allocated yet
        queue_request(CMD_ALLOC, 16'd4089, 12'hFFF);     // rounds to a full heap
        queue_request(CMD_ALLOC, 16'hFFFF, 12'd0);       // far too large
        queue_request(CMD_ALLOC, 16'd4088, 12'd0);       // largest legal block
        queue_request(CMD_ALLOC, 16'd1, 12'd0);          // only the last slot is left
        queue_request(CMD_QUERY, 16'd0, 12'd0);
        queue_request(CMD_QUERY, 16'd0, 12'd8);          // interior slot, not a base
        queue_request(CMD_FREE, 16'd0, 12'd4);           // misaligned
        queue_request(CMD_FREE, 16'd0, 12'hFFF);         // misaligned, top of range
        queue_request(CMD_FREE, 16'd0, 12'd4088);        // last slot, free
        queue_request(CMD_FREE, 16'd0, 12'd0);
        queue_request(CMD_FREE, 16'd0, 12'd0);           // double free
        queue_request(CMD_BAD, 16'hFFFF, 12'hFFF);
        queue_request(CMD_ALLOC, 16'd4000, 12'd0);       // 500 slots at 0
        queue_request(CMD_ALLOC, 16'd100, 12'd0);        // 13 slots would run off the end
        queue_request(CMD_ALLOC, 16'd88, 12'd0);         // 11 slots fit up to slot 510
        queue_request(CMD_ALLOC, 16'd8, 12'd0);          // last slot never starts a run
        queue_request(CMD_FREE, 16'd0, 12'd0);
        queue_request(CMD_ALLOC, 16'd9, 12'd0);          // 2 slots back at 0
        queue_request(CMD_ALLOC, 16'd3992, 12'd0);       // hits the block at 500, resumes
        queue_request(CMD_ALLOC, 16'd3984, 12'd0);       // exactly fills the gap
        queue_request(CMD_QUERY, 16'd0, 12'd16);
        queue_request(CMD_QUERY, 16'd0, 12'd4000);
        queue_request(CMD_FREE, 16'd0, 12'd4000);
        queue_request(CMD_FREE, 16'd0, 12'd16);
        queue_request(CMD_FREE, 16'd0, 12'd0);
        queue_phase(18, 73);

        for (n = 0; n < 3 * RAND_PER_PHASE; n++) begin
            if (n == RAND_PER_PHASE)
                queue_phase(73, 18);
            if (n == 2 * RAND_PER_PHASE)
                queue_phase(0, 0);
            while (pending_reqs.size() >= 2)
                @(posedge i_clk);
            queue_random_request();
        end

        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d requests over %0d drained phases: %0d allocations, %0d frees, %0d queries",
                 requests_sent, drains, allocs_granted, frees_done, queries_done);
        $display("error answers: %0d out-of-memory/bad-size, %0d bad pointer; %0d mismatches",
                 nomem_answers, badptr_answers, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
